>>> rtl/latest_message_buffer_pool_unit_defines.svh
// Assertion macros shared by the latest-message buffer pool RTL.
`ifndef LATEST_MESSAGE_BUFFER_POOL_UNIT_DEFINES_SVH
`define LATEST_MESSAGE_BUFFER_POOL_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LMBP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("buffer pool check failed");

// Next-cycle implication, checked outside reset.
`define LMBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("buffer pool check failed");

`endif

>>> rtl/lmbp_pkg.sv
// Package with sizes, operation codes and status codes of the buffer pool.
`default_nettype none

package lmbp_pkg;

  localparam int unsigned NUM_BUFFERS = 8;
  localparam int unsigned USE_BITS    = 8;

  localparam int unsigned IDX_W  = $clog2(NUM_BUFFERS);
  localparam int unsigned LINK_W = $clog2(NUM_BUFFERS + 1);

  localparam logic [LINK_W-1:0]   NULL_LINK = LINK_W'(NUM_BUFFERS);
  localparam logic [USE_BITS-1:0] USE_MAX   = {USE_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_PUBLISH = 2'd1,
    OP_TAKE    = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NOMSG = 2'd2,
    ST_ERR   = 2'd3
  } status_e;

endpackage

`default_nettype wire

>>> rtl/latest_message_buffer_pool_unit.sv
// Top level of the latest-message buffer pool: bookkeeping for a cyclic asynchronous buffer.
`default_nettype none

// Usage
// -----
// A command word (op_i, buffer_index_i) is taken at a rising edge where start_i
// is high and busy_o is low. busy_o is held low, so a command may be issued in
// every cycle. Operations: reserve a free buffer, publish a buffer as the
// latest message, take the latest message (raises its use count) and release
// a taken buffer.
// Every command yields exactly one result word (result_index_o, status_o),
// shown for one cycle with done_o high. The receiver cannot stall, so results
// leave in command order without back-pressure.
// The command is captured in an input register, and in the next cycle a
// single pass of logic reads at most one use count and one free-list link,
// updates the pool state and loads the result register.
// Throughput is one command per cycle; the state written by one command is
// already visible to the command right behind it.
// Reset (rst_ni low, asynchronous) chains all buffers onto the free list in
// index order, clears every use count, and marks that no message exists yet.
// No clearing pass is needed after reset.

module latest_message_buffer_pool_unit
  import lmbp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire logic [1:0]       op_i,
  input  wire logic [IDX_W-1:0] buffer_index_i,
  output logic                  done_o,
  output logic [IDX_W-1:0]      result_index_o,
  output logic [1:0]            status_o
);

`include "latest_message_buffer_pool_unit_defines.svh"

  // Input register stage.
  logic             valid_q;
  op_e              op_q;
  logic [IDX_W-1:0] idx_q;

  // Pool state.
  logic [USE_BITS-1:0] use_q  [NUM_BUFFERS];
  logic [LINK_W-1:0]   link_q [NUM_BUFFERS];
  logic [LINK_W-1:0]   free_head_q, free_head_d;
  logic [LINK_W-1:0]   latest_q, latest_d;

  // Result register stage.
  logic             done_q;
  logic [IDX_W-1:0] res_q, res_d;
  status_e          status_q, status_d;

  // Single write port into each state array.
  logic                use_we;
  logic [USE_BITS-1:0] use_wdata;
  logic                link_we;
  logic [IDX_W-1:0]    link_waddr;

  // Shared read of one use count.
  logic [IDX_W-1:0]    cnt_addr;
  logic [USE_BITS-1:0] cnt;
  logic                latest_ok;
  logic                idx_ok;
  logic                free_ok;

  // The block never holds commands off.
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q  <= op_e'(op_i);
      idx_q <= buffer_index_i;
    end
  end

  assign latest_ok = (latest_q < NULL_LINK);
  assign idx_ok    = (LINK_W'(idx_q) < NULL_LINK);
  assign free_ok   = (free_head_q < NULL_LINK);

  // Take and publish look at the latest buffer's count; release looks at the
  // named buffer's count. Reserve does not use it.
  assign cnt_addr = (op_q inside {OP_TAKE, OP_PUBLISH}) ? latest_q[IDX_W-1:0] : idx_q;
  assign cnt      = use_q[cnt_addr];

  always_comb begin
    free_head_d = free_head_q;
    latest_d    = latest_q;
    use_we      = 1'b0;
    use_wdata   = cnt;
    link_we     = 1'b0;
    link_waddr  = cnt_addr;
    res_d       = '0;
    status_d    = ST_OK;

    case (op_q)
      OP_RESERVE: begin
        if (!free_ok) begin
          status_d = ST_EMPTY;
        end else begin
          res_d       = free_head_q[IDX_W-1:0];
          free_head_d = link_q[free_head_q[IDX_W-1:0]];
        end
      end
      OP_PUBLISH: begin
        if (!idx_ok) begin
          status_d = ST_ERR;
        end else begin
          // The outgoing latest buffer goes back to the free list when no
          // reader holds it; republishing the same buffer keeps it.
          if (latest_ok && (latest_q[IDX_W-1:0] != idx_q) && (cnt == '0)) begin
            link_we     = 1'b1;
            link_waddr  = latest_q[IDX_W-1:0];
            free_head_d = latest_q;
          end
          latest_d = LINK_W'(idx_q);
        end
      end
      OP_TAKE: begin
        if (!latest_ok) begin
          status_d = ST_NOMSG;
        end else if (cnt == USE_MAX) begin
          status_d = ST_ERR;
        end else begin
          use_we    = 1'b1;
          use_wdata = cnt + USE_BITS'(1);
          res_d     = latest_q[IDX_W-1:0];
        end
      end
      OP_RELEASE: begin
        if (!idx_ok || (cnt == '0)) begin
          status_d = ST_ERR;
        end else begin
          use_we    = 1'b1;
          use_wdata = cnt - USE_BITS'(1);
          // Last reader gone and no longer the latest message: free it.
          if ((cnt == USE_BITS'(1)) && (LINK_W'(idx_q) != latest_q)) begin
            link_we     = 1'b1;
            link_waddr  = idx_q;
            free_head_d = LINK_W'(idx_q);
          end
        end
      end
      default: begin
        status_d = ST_ERR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        use_q[i]  <= '0;
        link_q[i] <= LINK_W'(i + 1);
      end
      free_head_q <= '0;
      latest_q    <= NULL_LINK;
    end else if (valid_q) begin
      if (use_we) begin
        use_q[cnt_addr] <= use_wdata;
      end
      if (link_we) begin
        link_q[link_waddr] <= free_head_q;
      end
      free_head_q <= free_head_d;
      latest_q    <= latest_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      res_q    <= res_d;
      status_q <= status_d;
    end
  end

  assign done_o         = done_q;
  assign result_index_o = res_q;
  assign status_o       = status_q;

  // Every captured command produces a result word in the following cycle.
  `LMBP_ASSERT_NEXT(a_cmd_gives_result, valid_q, done_o)
  // No result word appears without a captured command.
  `LMBP_ASSERT_NEXT(a_no_spurious_result, !valid_q, !done_o)
  // The free-list head always names a buffer or the null code.
  `LMBP_ASSERT_NOW(a_free_head_range, 1'b1, free_head_q <= NULL_LINK)
  // Once a message exists, there is always a latest message.
  `LMBP_ASSERT_NEXT(a_latest_sticks, latest_q < NULL_LINK, latest_q < NULL_LINK)

endmodule

`default_nettype wire

>>> tb/latest_message_buffer_pool_unit_test.sv
// Self-checking testbench for the latest-message buffer pool unit.
`default_nettype none

module latest_message_buffer_pool_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lmbp_pkg::*;

  // One result word as the block reports it.
  typedef struct packed {
    logic [IDX_W-1:0] index;
    status_e          status;
  } pool_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic [1:0]       op_i = OP_RESERVE;
  logic [IDX_W-1:0] buffer_index_i = '0;
  logic             busy_o;
  logic             done_o;
  logic [IDX_W-1:0] result_index_o;
  logic [1:0]       status_o;

  latest_message_buffer_pool_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .buffer_index_i (buffer_index_i),
    .done_o         (done_o),
    .result_index_o (result_index_o),
    .status_o       (status_o)
  );

  // 20 ns clock period.
  always begin
    #10;
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
  end

  // Our own copy of the pool bookkeeping, advanced once per accepted word.
  logic [USE_BITS-1:0] pool_use_count [NUM_BUFFERS];
  logic [LINK_W-1:0]   pool_next_link [NUM_BUFFERS];
  logic [LINK_W-1:0]   pool_free_head;
  logic [LINK_W-1:0]   pool_latest;

  // Results still owed by the block, oldest first.
  pool_result_t expected_results [$];

  int  mismatch_count = 0;
  // When set, the sender issues words back to back with no idle cycles.
  bit  burst_mode = 1'b0;

  // Buffers currently held by simulated readers, and the one the writer holds.
  logic [IDX_W-1:0] reader_held [$];
  int               writer_held = -1;

  // Puts the pool into its post-reset shape: all buffers chained in index order,
  // no reader counts and no published message.
  task automatic clear_pool_model();
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      pool_use_count[i] = '0;
      pool_next_link[i] = LINK_W'(i + 1);
    end
    pool_free_head = '0;
    pool_latest    = NULL_LINK;
  endtask

  // Puts buffer b on top of the free list; the null code is ignored.
  function automatic void pool_push_free(logic [LINK_W-1:0] b);
    if (b < NULL_LINK) begin
      pool_next_link[b[IDX_W-1:0]] = pool_free_head;
      pool_free_head = b;
    end
  endfunction

  // Applies one command word to the model state and returns the result word
  // the block must report for it.
  function automatic pool_result_t pool_apply(op_e op, logic [IDX_W-1:0] idx);
    pool_result_t      r;
    logic [LINK_W-1:0] b;
    r.index  = '0;
    r.status = ST_OK;
    b        = LINK_W'(idx);
    case (op)
      OP_RESERVE: begin
        if (pool_free_head >= NULL_LINK) begin
          r.status = ST_EMPTY;
        end else begin
          r.index        = pool_free_head[IDX_W-1:0];
          pool_free_head = pool_next_link[pool_free_head[IDX_W-1:0]];
        end
      end
      OP_PUBLISH: begin
        if (b >= NULL_LINK) begin
          r.status = ST_ERR;
        end else begin
          // The old latest buffer goes back only if nobody reads it and it is
          // not simply being published again.
          if (pool_latest < NULL_LINK && pool_latest != b &&
              pool_use_count[pool_latest[IDX_W-1:0]] == '0) begin
            pool_push_free(pool_latest);
          end
          pool_latest = b;
        end
      end
      OP_TAKE: begin
        if (pool_latest >= NULL_LINK) begin
          r.status = ST_NOMSG;
        end else if (pool_use_count[pool_latest[IDX_W-1:0]] >= USE_MAX) begin
          r.status = ST_ERR;
        end else begin
          pool_use_count[pool_latest[IDX_W-1:0]] += 1'b1;
          r.index = pool_latest[IDX_W-1:0];
        end
      end
      default: begin
        if (b >= NULL_LINK || pool_use_count[idx] == '0) begin
          r.status = ST_ERR;
        end else begin
          pool_use_count[idx] -= 1'b1;
          if (pool_use_count[idx] == '0 && b != pool_latest) begin
            pool_push_free(b);
          end
        end
      end
    endcase
    return r;
  endfunction

  // Sends one command word. The caller is at a rising edge; an idle gap may be
  // inserted first. The word is taken at the edge where start is high and busy
  // is low, and its expected result is queued right then.
  task automatic send_word(input op_e op, input logic [IDX_W-1:0] idx,
                           output pool_result_t predicted);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    op_i           <= op;
    buffer_index_i <= idx;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predicted = pool_apply(op, idx);
    expected_results.push_back(predicted);
  endtask

  // Result checker: every strobed word is matched against the oldest
  // expectation. Sampling at the edge sees the values of the cycle that ends.
  always @(posedge clk_i) begin
    pool_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word: index %0d status %0d", $time,
                 result_index_o, status_o);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (result_index_o !== want.index) begin
          $display("%0t: result_index expected %0d actual %0d", $time,
                   want.index, result_index_o);
          mismatch_count++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, status_o);
          mismatch_count++;
        end
      end
    end
  end

  // Reset is held asserted and then released on a rising edge.
  task automatic reset_pool();
    clear_pool_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  // Operations on a fresh pool: take and release with no message, and draining
  // the free list to empty, then one more reserve and take.
  task automatic test_empty_pool_and_no_message();
    pool_result_t r;
    send_word(OP_TAKE, 3'd5, r);       // no message yet
    send_word(OP_RELEASE, 3'd0, r);    // count underflow
    send_word(OP_RELEASE, 3'd7, r);    // count underflow, top index
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      send_word(OP_RESERVE, IDX_W'(i), r);
    end
    send_word(OP_RESERVE, 3'd0, r);    // pool empty
    send_word(OP_TAKE, 3'd0, r);       // still no message
  endtask

  // Publishing over held and unheld buffers, republishing the current buffer,
  // and publishing a buffer that sits on the free list.
  task automatic test_publish_and_hold();
    pool_result_t r;
    send_word(OP_PUBLISH, 3'd7, r);
    send_word(OP_PUBLISH, 3'd7, r);    // republish keeps it in place
    send_word(OP_RESERVE, 3'd0, r);    // nothing came back
    send_word(OP_TAKE, 3'd2, r);
    send_word(OP_PUBLISH, 3'd3, r);    // old latest is held, stays out
    send_word(OP_RESERVE, 3'd0, r);
    send_word(OP_RELEASE, 3'd7, r);    // last reader of a stale buffer frees it
    send_word(OP_RESERVE, 3'd0, r);
    send_word(OP_PUBLISH, 3'd0, r);    // unheld old latest goes back
    send_word(OP_PUBLISH, 3'd3, r);    // publish a buffer that is free
    send_word(OP_RESERVE, 3'd0, r);
    send_word(OP_RESERVE, 3'd0, r);
  endtask

  // Drives one buffer's use count to saturation and back to zero, one step past each end.
  task automatic test_use_count_limits();
    pool_result_t r;
    burst_mode = 1'b1;
    send_word(OP_PUBLISH, 3'd6, r);
    for (int i = 0; i <= int'(USE_MAX); i++) begin
      send_word(OP_TAKE, 3'd0, r);     // the last one hits saturation
    end
    burst_mode = 1'b0;
    send_word(OP_PUBLISH, 3'd1, r);    // 6 is held, so it is not freed
    burst_mode = 1'b1;
    for (int i = 0; i <= int'(USE_MAX); i++) begin
      send_word(OP_RELEASE, 3'd6, r);  // the last one underflows
    end
    burst_mode = 1'b0;
    send_word(OP_RESERVE, 3'd0, r);
  endtask

  // Writer and reader traffic with random content: the writer reserves and
  // publishes, readers take and later release. About one word in ten is noise.
  task automatic test_random_traffic(input int word_total);
    pool_result_t     r;
    int               pick;
    int               slot;
    op_e              op;
    logic [IDX_W-1:0] idx;
    reader_held.delete();
    writer_held = -1;
    for (int n = 0; n < word_total; n++) begin
      if (n % 100 == 0) begin
        burst_mode = ($urandom_range(0, 3) == 0);
      end
      idx  = IDX_W'($urandom_range(0, NUM_BUFFERS - 1));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        op = op_e'($urandom_range(0, 3));
      end else if (reader_held.size() > 24 || (pick < 35 && reader_held.size() > 0)) begin
        op   = OP_RELEASE;
        slot = $urandom_range(0, reader_held.size() - 1);
        idx  = reader_held[slot];
        reader_held.delete(slot);
      end else if (pick < 55) begin
        op = (writer_held < 0) ? OP_RESERVE : OP_PUBLISH;
        if (writer_held >= 0) begin
          idx = IDX_W'(writer_held);
        end
      end else begin
        op = OP_TAKE;
      end
      send_word(op, idx, r);
      // Track ownership from the predicted outcome.
      if (op == OP_RESERVE && r.status == ST_OK) begin
        writer_held = r.index;
      end else if (op == OP_PUBLISH && pick >= 10) begin
        writer_held = -1;
      end else if (op == OP_TAKE && r.status == ST_OK) begin
        reader_held.push_back(r.index);
      end
    end
  endtask

  // Stops issuing, waits for every owed word, and reports.
  task automatic finish_run();
    int wait_cycles;
    start_i <= 1'b0;
    wait_cycles = 0;
    while (expected_results.size() > 0 && wait_cycles < 1000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (4) @(posedge clk_i);
    if (expected_results.size() > 0) begin
      $display("%0t: %0d result words never arrived", $time, expected_results.size());
      mismatch_count += expected_results.size();
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  endtask

  initial begin
    reset_pool();
    test_empty_pool_and_no_message();
    test_publish_and_hold();
    test_use_count_limits();
    test_random_traffic(810);
    finish_run();
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
